/* rtl/occw_pkg.sv */
// shared constants and types for the countdown warning block
package occw_pkg;

    localparam int NUM_THRESH_REGS    = 4;
    localparam int MAX_THRESHOLDS_DEF = 4;
    localparam int SECS_PER_MIN       = 60;

    localparam int THRESH_W = 16;
    localparam int SECS_W   = 32;
    localparam int COUNT_W  = 3;

    // thresholds scaled to seconds fit in 22 bits, compared as 33-bit signed
    localparam int SCALED_W  = 22;
    localparam int CMP_W     = SECS_W + 1;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_COUNT = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_0  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_1  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_2  = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_3  = REG_IDX_W'(4);

    localparam logic MODE_CHECK = 1'b0;
    localparam logic MODE_REARM = 1'b1;

    typedef struct packed {
        logic                warn_valid;
        logic [THRESH_W-1:0] warn_minutes;
    } t_result;

endpackage

/* rtl/occw_ifs.sv */
// valid/ready channel interfaces for input words and result words
interface occw_in_if;
    import occw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [SECS_W-1:0] seconds_left;

    modport source (output valid, output mode, output seconds_left, input ready);
    modport sink   (input valid, input mode, input seconds_left, output ready);
endinterface

interface occw_out_if;
    import occw_pkg::*;

    logic                valid;
    logic                ready;
    logic                warn_valid;
    logic [THRESH_W-1:0] warn_minutes;

    modport source (output valid, output warn_valid, output warn_minutes, input ready);
    modport sink   (input valid, input warn_valid, input warn_minutes, output ready);
endinterface

/* rtl/one_shot_countdown_warning.sv */
// one-shot countdown warning: threshold compare, fired marks, apb registers
//
// Usage:
//   i_in carries one word per check (mode = check, seconds_left = time to the
//   deadline) or a rearm (mode = rearm), which clears every fired mark.
//   o_out returns exactly one word per input word: warn_valid with the
//   smallest threshold (minutes) that fired on this check, else zeros.
//   The APB port holds active_count at 0x00 and threshold_0..3 at 0x04..0x10;
//   any write to one of them clears the fired marks. pready is always high.
//   The result is held in the output register (or in the skid register while
//   o_out stalls) before o_out shows it. Throughput: one word per cycle while
//   i_in.ready is high, set by the single compare-and-min stage that feeds the
//   output register and reads the fired marks it wrote the cycle before.
//   When the receiver stalls, one more word is taken into a skid register;
//   i_in.ready drops only while that skid register is full.
//   Reset (i_rst_n low at a clock edge) clears the APB registers, the fired
//   marks and the valid flags of both output stages.
module one_shot_countdown_warning #(
    parameter int MAX_THRESHOLDS = occw_pkg::MAX_THRESHOLDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    occw_in_if.sink                         i_in,
    occw_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [occw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [occw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [occw_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import occw_pkg::*;

    localparam int LANES = (MAX_THRESHOLDS < NUM_THRESH_REGS) ? MAX_THRESHOLDS
                                                              : NUM_THRESH_REGS;

    logic [COUNT_W-1:0]  r_active_count, n_active_count;
    logic [THRESH_W-1:0] r_threshold [NUM_THRESH_REGS];
    logic [THRESH_W-1:0] n_threshold [NUM_THRESH_REGS];
    logic [LANES-1:0]    r_fired, n_fired;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic                 cfg_wr;
    logic                 cfg_hit;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 in_accept;
    logic                 out_take;
    logic                 is_check;
    logic [LANES-1:0]     new_fire;
    logic [CMP_W-1:0]     secs_ext;
    logic [SCALED_W-1:0]  scaled [LANES];
    t_result              result;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_wr    = psel & penable & pwrite & pready;
    assign cfg_hit   = (reg_idx == REG_ACTIVE_COUNT) || (reg_idx == REG_THRESHOLD_0) ||
                       (reg_idx == REG_THRESHOLD_1)  || (reg_idx == REG_THRESHOLD_2) ||
                       (reg_idx == REG_THRESHOLD_3);

    assign i_in.ready = !r_skid_valid;
    assign in_accept  = i_in.valid & i_in.ready;
    assign out_take   = r_out_valid & o_out.ready;
    assign is_check   = (i_in.mode == MODE_CHECK);

    assign secs_ext = {i_in.seconds_left[SECS_W-1], i_in.seconds_left};

    // lane i is in use when i < active_count; lanes past LANES never exist
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            // t * 60 = t * 64 - t * 4
            scaled[i]   = ({{(SCALED_W-THRESH_W){1'b0}}, r_threshold[i]} << 6)
                        - ({{(SCALED_W-THRESH_W){1'b0}}, r_threshold[i]} << 2);
            new_fire[i] = is_check && (COUNT_W'(i) < r_active_count) && !r_fired[i] &&
                          ($signed({{(CMP_W-SCALED_W){1'b0}}, scaled[i]}) >=
                           $signed(secs_ext));
        end
    end

    // smallest newly fired threshold
    always_comb begin
        result.warn_valid   = 1'b0;
        result.warn_minutes = '0;
        for (int i = 0; i < LANES; i++) begin
            if (new_fire[i] &&
                (!result.warn_valid || (r_threshold[i] < result.warn_minutes))) begin
                result.warn_valid   = 1'b1;
                result.warn_minutes = r_threshold[i];
            end
        end
    end

    // register file and fired marks
    always_comb begin
        n_active_count = r_active_count;
        n_threshold    = r_threshold;
        n_fired        = r_fired;
        if (in_accept) begin
            if (is_check) begin
                n_fired = r_fired | new_fire;
            end else begin
                n_fired = '0;
            end
        end
        if (cfg_wr && cfg_hit) begin
            n_fired = '0;
            unique case (reg_idx)
                REG_ACTIVE_COUNT: n_active_count = pwdata[COUNT_W-1:0];
                REG_THRESHOLD_0:  n_threshold[0] = pwdata[THRESH_W-1:0];
                REG_THRESHOLD_1:  n_threshold[1] = pwdata[THRESH_W-1:0];
                REG_THRESHOLD_2:  n_threshold[2] = pwdata[THRESH_W-1:0];
                REG_THRESHOLD_3:  n_threshold[3] = pwdata[THRESH_W-1:0];
                default:          n_fired = r_fired;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ACTIVE_COUNT: prdata = APB_DATA_W'(r_active_count);
            REG_THRESHOLD_0:  prdata = APB_DATA_W'(r_threshold[0]);
            REG_THRESHOLD_1:  prdata = APB_DATA_W'(r_threshold[1]);
            REG_THRESHOLD_2:  prdata = APB_DATA_W'(r_threshold[2]);
            REG_THRESHOLD_3:  prdata = APB_DATA_W'(r_threshold[3]);
            default:          prdata = '0;
        endcase
    end

    // output register plus skid register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (in_accept) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_accept) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
            r_threshold    <= '{default: '0};
            r_fired        <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            r_active_count <= n_active_count;
            r_threshold    <= n_threshold;
            r_fired        <= n_fired;
            r_out_valid    <= n_out_valid;
            r_skid_valid   <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.warn_valid   = r_out.warn_valid;
    assign o_out.warn_minutes = r_out.warn_minutes;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held while output register is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("word taken during stall was not kept in skid register");

    a_rearm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.mode == MODE_REARM) |=> (r_fired == '0))
        else $error("fired marks not cleared after rearm");

    a_no_warn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.warn_valid) |-> (o_out.warn_minutes == '0))
        else $error("warn_minutes nonzero without a warning");
`endif

endmodule
